>>> sv/sorted_record_table_top_defines.svh
// ----------------------------------------------------------------------------
// sorted record table assertion macros
// shared property forms for the table sequencer checks
// ----------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_TOP_DEFINES_SVH
`define SORTED_RECORD_TABLE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// sizes, record type and codes of the sorted record table
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // field widths
  localparam int KEY_W       = 32;
  localparam int GRADE_W     = 7;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 6;

  localparam logic [GRADE_W-1:0] GRADE_MAX  = 7'd100;
  localparam logic [GRADE_W-1:0] THR_RESET  = 7'd70;

  // opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  // one stored record
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [GRADE_W-1:0]      grade;
    logic                    passed;
  } rec_t;

endpackage

`default_nettype wire

>>> sv/srt_in_if.sv
// ----------------------------------------------------------------------------
// srt_in_if
// request channel of the sorted record table: opcode, key and grade
// ----------------------------------------------------------------------------
`default_nettype none

interface srt_in_if import srt_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [KEY_W-1:0] key;
  logic [GRADE_W-1:0]      grade_tenths;

  modport source (output valid, output opcode, output key, output grade_tenths,
                  input ready);
  modport sink   (input valid, input opcode, input key, input grade_tenths,
                  output ready);

endinterface

`default_nettype wire

>>> sv/srt_out_if.sv
// ----------------------------------------------------------------------------
// srt_out_if
// result channel of the sorted record table: status, record and table size
// ----------------------------------------------------------------------------
`default_nettype none

interface srt_out_if import srt_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [KEY_W-1:0] rec_key;
  logic [GRADE_W-1:0]      rec_grade;
  logic                    rec_passed;
  logic [COUNT_OUT_W-1:0]  entry_count;
  logic                    is_empty;
  logic                    last;

  modport source (output valid, output status, output rec_key, output rec_grade,
                  output rec_passed, output entry_count, output is_empty,
                  output last, input ready);
  modport sink   (input valid, input status, input rec_key, input rec_grade,
                  input rec_passed, input entry_count, input is_empty,
                  input last, output ready);

endinterface

`default_nettype wire

>>> sv/sorted_record_table_top.sv
// ----------------------------------------------------------------------------
// sorted_record_table_top
// table of records kept in ascending signed key order, at most one memory walk per op
// ----------------------------------------------------------------------------
// usage
//   in_ch takes one request word (opcode, key, grade_tenths) when valid and
//   ready meet; ready is high only while the sequencer is idle.
//   out_ch gives result words from an output register; dump gives one word
//   per record in key order, every other opcode gives one word, last marks
//   the final word of a request.
//   cfg_wr_en/cfg_wr_data write the pass threshold (write only while idle).
// timing
//   one record memory with a registered read, walked one entry per cycle
//   (a dump walk waits while out_ch stalls). insert walks down from the top,
//   moving each entry at or above the insert point up one slot, then writes
//   the new record; remove/search walk up from the front to the first match,
//   and remove then moves each later entry down one slot; dump streams every
//   entry; count, clear and refused requests do no walk.
// reset and stall
//   reset empties the table and sets the threshold to 70; the memory is not
//   cleared, entries above the count are never used. a stalled receiver holds
//   the output word and the dump walk waits; a new request is taken while the
//   last result word still waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_record_table_top_defines.svh"

module sorted_record_table_top import srt_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  srt_in_if.sink             in_ch,
  srt_out_if.source          out_ch,
  input  wire logic          cfg_wr_en,
  input  wire logic [GRADE_W-1:0] cfg_wr_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_INS   = 7'b0000100,
    S_PUT   = 7'b0001000,
    S_FIND  = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_DUMP  = 7'b1000000
  } state_t;

  // DONE is folded into a flag so the one-hot set stays small
  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  logic [OP_W-1:0]         op_r, op_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [GRADE_W-1:0]      grade_r, grade_nxt;
  logic                    passed_r, passed_nxt;
  logic [GRADE_W-1:0]      thr_r, thr_nxt;
  cnt_t                    count_r, count_nxt;
  cnt_t                    idx_r, idx_nxt;

  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  rec_t                    res_rec_r, res_rec_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  rec_t                    out_rec_r, out_rec_nxt;
  logic [COUNT_OUT_W-1:0]  out_count_r, out_count_nxt;
  logic                    out_empty_r, out_empty_nxt;
  logic                    out_last_r, out_last_nxt;

  // record memory
  rec_t mem [TABLE_DEPTH];
  rec_t rd_data_r;
  idx_t rd_addr;
  logic wr_en;
  idx_t wr_addr;
  rec_t wr_data;

  logic [GRADE_W-1:0] grade_sat;
  logic               slot_free;
  rec_t               new_rec;
  cnt_t               idx_m1, idx_m2, idx_p1, idx_p2, cnt_m1;
  logic               key_lt, key_eq;

  assign in_ch.ready        = (state_r == S_IDLE) && !done_r;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.rec_key     = out_rec_r.key;
  assign out_ch.rec_grade   = out_rec_r.grade;
  assign out_ch.rec_passed  = out_rec_r.passed;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.last        = out_last_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign grade_sat = (in_ch.grade_tenths > GRADE_MAX) ? GRADE_MAX : in_ch.grade_tenths;
  assign new_rec   = '{key: key_r, grade: grade_r, passed: passed_r};
  assign idx_m1    = idx_r - cnt_t'(1);
  assign idx_m2    = idx_r - cnt_t'(2);
  assign idx_p1    = idx_r + cnt_t'(1);
  assign idx_p2    = idx_r + cnt_t'(2);
  assign cnt_m1    = count_r - cnt_t'(1);

  // shared key comparator
  assign key_lt = rd_data_r.key < key_r;
  assign key_eq = rd_data_r.key == key_r;

  // memory: at most one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    done_nxt       = done_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    grade_nxt      = grade_r;
    passed_nxt     = passed_r;
    thr_nxt        = cfg_wr_en ? cfg_wr_data : thr_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_last_nxt   = out_last_r;
    rd_addr        = idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = idx_r[IDX_W-1:0];
    wr_data        = new_rec;

    // single result word waiting for the output register
    if (done_r) begin
      if (slot_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status_r;
        out_rec_nxt    = res_rec_r;
        out_count_nxt  = COUNT_OUT_W'(count_r);
        out_empty_nxt  = (count_r == '0);
        out_last_nxt   = 1'b1;
        done_nxt       = 1'b0;
        state_nxt      = S_IDLE;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_nxt     = in_ch.opcode;
            key_nxt    = in_ch.key;
            grade_nxt  = grade_sat;
            passed_nxt = (grade_sat >= thr_r);
            state_nxt  = S_START;
          end
        end

        S_START: begin
          res_status_nxt = ST_OK;
          res_rec_nxt    = '0;
          idx_nxt        = '0;
          rd_addr        = '0;
          case (op_r)
            OP_INSERT: begin
              if (count_r >= cnt_t'(TABLE_DEPTH)) begin
                res_status_nxt = ST_FULL;
                done_nxt       = 1'b1;
              end else if (count_r == '0) begin
                state_nxt = S_PUT;
              end else begin
                rd_addr   = cnt_m1[IDX_W-1:0];
                idx_nxt   = count_r;
                state_nxt = S_INS;
              end
            end
            OP_REMOVE, OP_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                done_nxt       = 1'b1;
              end else begin
                state_nxt = S_FIND;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              done_nxt  = 1'b1;
            end
            OP_DUMP: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                done_nxt       = 1'b1;
              end else begin
                state_nxt = S_DUMP;
              end
            end
            default: begin
              done_nxt = 1'b1;
            end
          endcase
        end

        // walk down from the top, moving larger-or-equal keys up one slot
        S_INS: begin
          if (!key_lt) begin
            wr_en   = 1'b1;
            wr_data = rd_data_r;
            idx_nxt = idx_m1;
            rd_addr = idx_m2[IDX_W-1:0];
            if (idx_r == cnt_t'(1)) begin
              state_nxt = S_PUT;
            end
          end else begin
            state_nxt = S_PUT;
          end
        end

        // drop the new record into the opened slot
        S_PUT: begin
          wr_en          = 1'b1;
          wr_data        = new_rec;
          count_nxt      = count_r + cnt_t'(1);
          res_status_nxt = ST_OK;
          res_rec_nxt    = new_rec;
          done_nxt       = 1'b1;
        end

        // walk up for the first matching key
        S_FIND: begin
          if (key_eq) begin
            res_status_nxt = ST_OK;
            res_rec_nxt    = '{key: key_r, grade: rd_data_r.grade,
                               passed: rd_data_r.passed};
            if (op_r == OP_SEARCH) begin
              done_nxt = 1'b1;
            end else if (idx_p1 < count_r) begin
              rd_addr   = idx_p1[IDX_W-1:0];
              state_nxt = S_SHIFT;
            end else begin
              count_nxt = cnt_m1;
              done_nxt  = 1'b1;
            end
          end else if (idx_p1 < count_r) begin
            rd_addr = idx_p1[IDX_W-1:0];
            idx_nxt = idx_p1;
          end else begin
            res_status_nxt = ST_NOTFOUND;
            done_nxt       = 1'b1;
          end
        end

        // close the gap, one record down per cycle
        S_SHIFT: begin
          wr_en   = 1'b1;
          wr_data = rd_data_r;
          idx_nxt = idx_p1;
          rd_addr = idx_m2[IDX_W-1:0];
          if (idx_p1 < cnt_m1) begin
            rd_addr = idx_p2[IDX_W-1:0];
          end else begin
            count_nxt = cnt_m1;
            done_nxt  = 1'b1;
          end
        end

        // stream every record, re-read the same entry while stalled
        S_DUMP: begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_rec_nxt    = rd_data_r;
            out_count_nxt  = COUNT_OUT_W'(count_r);
            out_empty_nxt  = 1'b0;
            out_last_nxt   = (idx_p1 == count_r);
            idx_nxt        = idx_p1;
            rd_addr        = idx_p1[IDX_W-1:0];
            if (idx_p1 == count_r) begin
              state_nxt = S_IDLE;
            end
          end
        end

        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_r      <= 1'b0;
      thr_r       <= THR_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      thr_r       <= thr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    grade_r      <= grade_nxt;
    passed_r     <= passed_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_last_r   <= out_last_nxt;
  end

  // checks
  `SRT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= cnt_t'(TABLE_DEPTH), "count above depth")
  `SRT_ASSERT_NOW(a_mid_word_dump, out_valid_r && !out_last_r, state_r == S_DUMP, "non-last word outside dump")
  `SRT_ASSERT_NEXT(a_put_grows, state_r == S_PUT && !done_r, count_r == $past(count_r) + cnt_t'(1), "insert did not grow count")
  `SRT_ASSERT_NEXT(a_accept_starts, in_ch.valid && in_ch.ready, state_r == S_START, "accepted word not started")

endmodule

`default_nettype wire

>>> tb/sv/srt_result_checker.sv
// ----------------------------------------------------------------------------
// srt_result_checker
// watches the request and result channels of the sorted record table, keeps
// its own ordered copy of the records and the pass threshold, predicts the
// result words of every accepted request and compares them field by field
// ----------------------------------------------------------------------------

module srt_result_checker import srt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  srt_in_if                   in_mon,
  srt_out_if                  out_mon,
  input  logic                cfg_wr_en,
  input  logic [GRADE_W-1:0]  cfg_wr_data,
  output int                  failures,
  output int                  outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  // one predicted result word
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] rec_key;
    logic [GRADE_W-1:0]      rec_grade;
    logic                    rec_passed;
    logic [COUNT_OUT_W-1:0]  entry_count;
    logic                    is_empty;
    logic                    last;
  } result_word_t;

  rec_t               recs [TABLE_DEPTH];
  int                 rec_count;
  logic [GRADE_W-1:0] threshold;
  result_word_t       expected_q [$];
  int                 mismatches;

  initial begin
    mismatches  = 0;
    failures    = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t checker: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  // size fields reflect the table after the request
  function automatic void queue_result(input logic [STATUS_W-1:0] st,
                                       input logic signed [KEY_W-1:0] k,
                                       input logic [GRADE_W-1:0] g,
                                       input logic p, input logic lst);
    result_word_t w;
    w.status      = st;
    w.rec_key     = k;
    w.rec_grade   = g;
    w.rec_passed  = p;
    w.entry_count = rec_count[COUNT_OUT_W-1:0];
    w.is_empty    = (rec_count == 0);
    w.last        = lst;
    expected_q.push_back(w);
  endfunction

  // apply one request to the local table and queue its result words
  task automatic predict_request(input logic [OP_W-1:0] op,
                                 input logic signed [KEY_W-1:0] k,
                                 input logic [GRADE_W-1:0] g);
    int                 pos;
    int                 i;
    rec_t               hit;
    logic [GRADE_W-1:0] gs;
    case (op)
      OP_INSERT: begin
        if (rec_count >= TABLE_DEPTH) begin
          queue_result(ST_FULL, '0, '0, 1'b0, 1'b1);
        end else begin
          gs = (g > GRADE_MAX) ? GRADE_MAX : g;
          // new record goes before the first key that is not smaller
          pos = 0;
          while (pos < rec_count && $signed(recs[pos].key) < $signed(k)) pos++;
          for (i = rec_count; i > pos; i--) recs[i] = recs[i-1];
          recs[pos].key    = k;
          recs[pos].grade  = gs;
          recs[pos].passed = (gs >= threshold);
          rec_count++;
          queue_result(ST_OK, k, gs, recs[pos].passed, 1'b1);
        end
      end
      OP_REMOVE, OP_SEARCH: begin
        if (rec_count == 0) begin
          queue_result(ST_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          pos = 0;
          while (pos < rec_count && recs[pos].key != k) pos++;
          if (pos >= rec_count) begin
            queue_result(ST_NOTFOUND, '0, '0, 1'b0, 1'b1);
          end else begin
            hit = recs[pos];
            if (op == OP_REMOVE) begin
              for (i = pos; i + 1 < rec_count; i++) recs[i] = recs[i+1];
              rec_count--;
            end
            queue_result(ST_OK, k, hit.grade, hit.passed, 1'b1);
          end
        end
      end
      OP_CLEAR: begin
        rec_count = 0;
        queue_result(ST_OK, '0, '0, 1'b0, 1'b1);
      end
      OP_DUMP: begin
        if (rec_count == 0) begin
          queue_result(ST_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < rec_count; i++)
            queue_result(ST_OK, recs[i].key, recs[i].grade, recs[i].passed,
                         i + 1 == rec_count);
        end
      end
      // count and the spare opcodes only report the size
      default: begin
        queue_result(ST_OK, '0, '0, 1'b0, 1'b1);
      end
    endcase
  endtask

  // compare an accepted result word with the oldest prediction
  task automatic check_result();
    result_word_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unrequested word", longint'(out_mon.rec_key), 0);
    end else begin
      want = expected_q.pop_front();
      if (out_mon.status !== want.status)
        report_mismatch("status", out_mon.status, want.status);
      if (out_mon.rec_key !== want.rec_key)
        report_mismatch("rec_key", longint'(out_mon.rec_key), longint'(want.rec_key));
      if (out_mon.rec_grade !== want.rec_grade)
        report_mismatch("rec_grade", out_mon.rec_grade, want.rec_grade);
      if (out_mon.rec_passed !== want.rec_passed)
        report_mismatch("rec_passed", out_mon.rec_passed, want.rec_passed);
      if (out_mon.entry_count !== want.entry_count)
        report_mismatch("entry_count", out_mon.entry_count, want.entry_count);
      if (out_mon.is_empty !== want.is_empty)
        report_mismatch("is_empty", out_mon.is_empty, want.is_empty);
      if (out_mon.last !== want.last)
        report_mismatch("last", out_mon.last, want.last);
    end
  endtask

  // sample both channels and the threshold port at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      rec_count = 0;
      threshold = THR_RESET;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        predict_request(in_mon.opcode, in_mon.key, in_mon.grade_tenths);
    end
    outstanding <= expected_q.size();
    failures    <= mismatches;
  end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives the sorted record table with directed requests (empty table, key
// extremes, duplicates, grade saturation, spare opcodes) and random request
// streams under several pass thresholds, fills the table to overflow, holds
// the result channel off for a long stretch, and reports the verdict
// ----------------------------------------------------------------------------

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 2 * TABLE_DEPTH + 8;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [GRADE_W-1:0] cfg_wr_data;
  int                 failures;
  int                 outstanding;
  int                 cycle_count;
  bit                 quiet_phase;
  bit                 hold_off_req;

  logic signed [KEY_W-1:0] used_keys [$];

  srt_in_if  in_ch ();
  srt_out_if out_ch ();

  sorted_record_table_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  srt_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("testbench: FAIL");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // keys already used, small keys near zero, or anything at all
  function automatic logic signed [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && used_keys.size() > 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if (sel < 7) return int'($urandom_range(0, 16)) - 8;
    return $urandom();
  endfunction

  function automatic logic [GRADE_W-1:0] pick_grade();
    if ($urandom_range(0, 9) == 0) return GRADE_W'($urandom_range(101, 127));
    return GRADE_W'($urandom_range(0, 100));
  endfunction

  // result side: random stalls, a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // offer one request word; valid stays high when the next word follows at once
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] k,
                           input logic [GRADE_W-1:0] g);
    int gap;
    gap = quiet_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.key          <= k;
    in_ch.grade_tenths <= g;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_INSERT) used_keys.push_back(k);
  endtask

  task automatic send_random_word();
    int                 r;
    logic [OP_W-1:0]    op;
    r = $urandom_range(0, 99);
    if (r < 40)      op = OP_INSERT;
    else if (r < 55) op = OP_REMOVE;
    else if (r < 70) op = OP_SEARCH;
    else if (r < 76) op = OP_COUNT;
    else if (r < 79) op = OP_CLEAR;
    else if (r < 90) op = OP_DUMP;
    else if (r < 95) op = OP_SPARE_A;
    else             op = OP_SPARE_B;
    send_word(op, pick_key(), pick_grade());
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random_word();
  endtask

  // drop valid and wait for every predicted word plus the tail of any shift
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [GRADE_W-1:0] thr);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // fill past capacity, then dump with the result side held off
  task automatic fill_and_hold();
    send_word(OP_CLEAR, pick_key(), pick_grade());
    repeat (TABLE_DEPTH + 2) send_word(OP_INSERT, pick_key(), pick_grade());
    hold_off_req = 1'b1;
    send_word(OP_DUMP, pick_key(), pick_grade());
    run_random(5);
  endtask

  // stimulus
  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_COUNT;
    in_ch.key          <= '0;
    in_ch.grade_tenths <= '0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    rst_n              <= 1'b0;
    quiet_phase  = 1'b0;
    hold_off_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_threshold(THR_RESET);

    // empty table answers
    send_word(OP_COUNT,  0, 0);
    send_word(OP_SEARCH, 0, 0);
    send_word(OP_REMOVE, 0, 0);
    send_word(OP_DUMP,   0, 0);
    // key extremes, saturated grades, duplicates around the threshold
    send_word(OP_INSERT, KEY_MAX, GRADE_MAX);
    send_word(OP_INSERT, KEY_MIN, 7'd0);
    send_word(OP_INSERT, 0, 7'd127);
    send_word(OP_INSERT, 5, 7'd69);
    send_word(OP_INSERT, 5, 7'd70);
    send_word(OP_INSERT, -1, 7'd101);
    // first match, miss, removal at both ends
    send_word(OP_SEARCH, 5, 0);
    send_word(OP_SEARCH, 1234, 0);
    send_word(OP_REMOVE, 5, 0);
    send_word(OP_REMOVE, KEY_MIN, 0);
    send_word(OP_REMOVE, KEY_MAX, 0);
    send_word(OP_DUMP, 0, 0);
    // spare opcodes, clear, count
    send_word(OP_SPARE_A, 7, 7'd3);
    send_word(OP_SPARE_B, -7, 7'd127);
    send_word(OP_COUNT, 0, 0);
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_COUNT, 0, 0);
    send_word(OP_DUMP, 0, 0);
    send_word(OP_INSERT, KEY_MIN, 7'd50);
    send_word(OP_REMOVE, KEY_MIN, 0);

    // random streams under several thresholds
    set_threshold(7'd0);
    run_random(15);
    set_threshold(GRADE_MAX);
    fill_and_hold();
    set_threshold(7'd127);
    quiet_phase = 1'b1;
    run_random(15);
    quiet_phase = 1'b0;
    set_threshold(GRADE_W'($urandom_range(1, 99)));
    run_random(15);

    wait_idle();
    if (failures == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
